// ===== src/assert_macros.svh =====
// assertion macros shared by the sorter rtl
// expects signals named clock and reset in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define QS_ASSERT_HOLDS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// implication checked outside reset
`define QS_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

// implication checked during reset too
`define QS_ASSERT_NEXT_RST(label, pre, post, msg) \
   label: assert property (@(posedge clock) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== src/qsort_pkg.sv =====
// package for the quicksort buffer sorter: state encoding and the
// command / status groups between controller and datapath; no dependencies
package qsort_pkg;

   localparam int VALUE_W = 16;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_SORT_INIT,
      ST_POP,
      ST_POP_WAIT,
      ST_PIV_RD,
      ST_PIV_WAIT,
      ST_SCAN_RD,
      ST_SCAN_WAIT,
      ST_SWAP_WAIT,
      ST_SWAP_WR,
      ST_FIN_RD,
      ST_FIN_WAIT,
      ST_FIN_WR,
      ST_PUSH_L,
      ST_PUSH_R,
      ST_EMIT_RD,
      ST_EMIT_WAIT,
      ST_EMIT_HOLD
   } state_type;

   // one-cycle commands from the controller
   typedef struct packed {
      logic load;          // store accepted sample, count it
      logic push_init;     // push whole set as first range
      logic pop;           // read top range, shrink stack
      logic take_range;    // latch lo/hi from stack data, j = nxt = lo
      logic read_pivot;    // read store at hi
      logic take_pivot;    // latch pivot from store data
      logic read_j;        // read store at j
      logic take_aj;       // latch store data as element j
      logic read_nxt;      // read store at nxt
      logic inc_j;
      logic inc_nxt;
      logic wr_j_rd;       // store[j] = store data
      logic wr_nxt_aj;     // store[nxt] = element j
      logic wr_hi_rd;      // store[hi] = store data
      logic wr_nxt_pivot;  // store[nxt] = pivot
      logic push_left;     // push (lo, nxt-1)
      logic push_right;    // push (nxt+1, hi)
      logic emit_start;    // j = 0
      logic emit_rd;       // read store at j for output
      logic emit_ld;       // load output register
      logic emit_done;     // clear count and overflow
   } cmd_type;

   // status back to the controller
   typedef struct packed {
      logic few_items;     // fewer than two samples loaded
      logic stack_empty;
      logic range_ok;      // popped lo below popped hi
      logic scan_end;      // j reached hi
      logic le_pivot;      // store data <= pivot, signed
      logic nxt_eq_j;
      logic nxt_eq_hi;
      logic left_ok;       // pivot slot above lo + 1
      logic right_ok;      // pivot slot + 1 below hi
      logic out_xfer;      // output transfer this cycle
      logic out_last;      // output register holds final result
   } status_type;

endpackage

// ===== src/quicksort_buffer_sorter.sv =====
// quicksort buffer sorter, top level
// depends on qsort_pkg, qsort_ctrl, qsort_dpath, assert_macros.svh
//
// usage:
//   req channel: one signed 16-bit sample per transfer; req_last_sample
//   closes the set. Up to MAX_ITEMS samples are kept, later ones of the
//   same set are dropped and rsp_overflow is set on all its results.
//   rsp channel: the set in ascending order, one value per transfer,
//   rsp_last_result on the final one.
//   loading: one sample per cycle. req_stall is high from the closing
//   sample until the final result has been taken.
//   sorting: a partition pass pops a range, reads the pivot at hi, reads
//   each scanned element and takes a read and two writes per swap and to
//   move the pivot, all bound by the single read port of the sample store;
//   n log n compares on average, n * n / 2 worst case (already sorted input).
//   output: each result takes a store read, an output load and a transfer;
//   a stalled result simply holds in the output register.
//   reset: synchronous; empties the set and the stack, drops any result.
//   store contents are not cleared and need no clearing pass.
`include "assert_macros.svh"

module quicksort_buffer_sorter #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [qsort_pkg::VALUE_W-1:0]  req_sample_value,
   input  logic                                  req_last_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [qsort_pkg::VALUE_W-1:0]  rsp_sorted_value,
   output logic                                  rsp_last_result,
   output logic                                  rsp_overflow
);

   qsort_pkg::cmd_type    cmd;
   qsort_pkg::status_type status;
   logic [4:0]            store_wr_sel;
   logic                  final_xfer;

   // sequencing
   qsort_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_sample (req_last_sample),
      .req_stall       (req_stall),
      .status          (status),
      .cmd             (cmd)
   );

   // storage and arithmetic
   qsort_dpath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample_value (req_sample_value),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_result  (rsp_last_result),
      .rsp_overflow     (rsp_overflow)
   );

   // terms for the checks
   assign store_wr_sel = {cmd.load, cmd.wr_j_rd, cmd.wr_nxt_aj, cmd.wr_hi_rd,
                          cmd.wr_nxt_pivot};
   assign final_xfer   = rsp_valid && !rsp_stall && rsp_last_result;

   // checks
   `QS_ASSERT_HOLDS(a_no_load_while_emit, !rsp_valid || req_stall, "sample taken in output")
   `QS_ASSERT_HOLDS(a_one_store_write, $onehot0(store_wr_sel), "two store writes at once")
   `QS_ASSERT_NEXT_RST(a_reset_drops_result, reset, !rsp_valid, "result valid after reset")
   `QS_ASSERT_NEXT(a_reopen_after_last, final_xfer, !req_stall, "input not reopened")

endmodule

// ===== src/qsort_ram.sv =====
// generic simple dual-port ram: one write port, one read port with
// registered read data; no dependencies
module qsort_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/qsort_ctrl.sv =====
// controller state machine for the quicksort buffer sorter
// depends on qsort_pkg; drives qsort_dpath through cmd_type
module qsort_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last_sample,
   output logic                 req_stall,
   input  qsort_pkg::status_type status,
   output qsort_pkg::cmd_type   cmd
);

   qsort_pkg::state_type state_ff;
   qsort_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qsort_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // input side open only while loading
   assign req_stall = reset || (state_ff != qsort_pkg::ST_LOAD);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         qsort_pkg::ST_LOAD: begin
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               if (req_last_sample) begin
                  state_in = qsort_pkg::ST_SORT_INIT;
               end
            end
         end
         qsort_pkg::ST_SORT_INIT: begin
            if (status.few_items) begin
               cmd.emit_start = 1'b1;
               state_in       = qsort_pkg::ST_EMIT_RD;
            end else begin
               cmd.push_init = 1'b1;
               state_in      = qsort_pkg::ST_POP;
            end
         end
         qsort_pkg::ST_POP: begin
            if (status.stack_empty) begin
               cmd.emit_start = 1'b1;
               state_in       = qsort_pkg::ST_EMIT_RD;
            end else begin
               cmd.pop  = 1'b1;
               state_in = qsort_pkg::ST_POP_WAIT;
            end
         end
         qsort_pkg::ST_POP_WAIT: begin
            cmd.take_range = 1'b1;
            state_in = status.range_ok ? qsort_pkg::ST_PIV_RD : qsort_pkg::ST_POP;
         end
         qsort_pkg::ST_PIV_RD: begin
            cmd.read_pivot = 1'b1;
            state_in       = qsort_pkg::ST_PIV_WAIT;
         end
         qsort_pkg::ST_PIV_WAIT: begin
            cmd.take_pivot = 1'b1;
            state_in       = qsort_pkg::ST_SCAN_RD;
         end
         qsort_pkg::ST_SCAN_RD: begin
            if (status.scan_end) begin
               state_in = qsort_pkg::ST_FIN_RD;
            end else begin
               cmd.read_j = 1'b1;
               state_in   = qsort_pkg::ST_SCAN_WAIT;
            end
         end
         qsort_pkg::ST_SCAN_WAIT: begin
            cmd.take_aj = 1'b1;
            if (status.le_pivot && status.nxt_eq_j) begin
               cmd.inc_j   = 1'b1;
               cmd.inc_nxt = 1'b1;
               state_in    = qsort_pkg::ST_SCAN_RD;
            end else if (status.le_pivot) begin
               cmd.read_nxt = 1'b1;
               state_in     = qsort_pkg::ST_SWAP_WAIT;
            end else begin
               cmd.inc_j = 1'b1;
               state_in  = qsort_pkg::ST_SCAN_RD;
            end
         end
         qsort_pkg::ST_SWAP_WAIT: begin
            cmd.wr_j_rd = 1'b1;
            state_in    = qsort_pkg::ST_SWAP_WR;
         end
         qsort_pkg::ST_SWAP_WR: begin
            cmd.wr_nxt_aj = 1'b1;
            cmd.inc_j     = 1'b1;
            cmd.inc_nxt   = 1'b1;
            state_in      = qsort_pkg::ST_SCAN_RD;
         end
         qsort_pkg::ST_FIN_RD: begin
            if (status.nxt_eq_hi) begin
               state_in = qsort_pkg::ST_PUSH_L;
            end else begin
               cmd.read_nxt = 1'b1;
               state_in     = qsort_pkg::ST_FIN_WAIT;
            end
         end
         qsort_pkg::ST_FIN_WAIT: begin
            cmd.wr_hi_rd = 1'b1;
            state_in     = qsort_pkg::ST_FIN_WR;
         end
         qsort_pkg::ST_FIN_WR: begin
            cmd.wr_nxt_pivot = 1'b1;
            state_in         = qsort_pkg::ST_PUSH_L;
         end
         qsort_pkg::ST_PUSH_L: begin
            cmd.push_left = status.left_ok;
            state_in      = qsort_pkg::ST_PUSH_R;
         end
         qsort_pkg::ST_PUSH_R: begin
            cmd.push_right = status.right_ok;
            state_in       = qsort_pkg::ST_POP;
         end
         qsort_pkg::ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = qsort_pkg::ST_EMIT_WAIT;
         end
         qsort_pkg::ST_EMIT_WAIT: begin
            cmd.emit_ld = 1'b1;
            state_in    = qsort_pkg::ST_EMIT_HOLD;
         end
         qsort_pkg::ST_EMIT_HOLD: begin
            if (status.out_xfer && status.out_last) begin
               cmd.emit_done = 1'b1;
               state_in      = qsort_pkg::ST_LOAD;
            end else if (status.out_xfer) begin
               cmd.inc_j = 1'b1;
               state_in  = qsort_pkg::ST_EMIT_RD;
            end
         end
         default: begin
            state_in = qsort_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

// ===== src/qsort_dpath.sv =====
// datapath for the quicksort buffer sorter: sample store, range stack,
// partition indexes and output register; depends on qsort_pkg, qsort_ram
module qsort_dpath #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  qsort_pkg::cmd_type                    cmd,
   output qsort_pkg::status_type                 status,
   input  logic signed [qsort_pkg::VALUE_W-1:0]  req_sample_value,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic signed [qsort_pkg::VALUE_W-1:0]  rsp_sorted_value,
   output logic                                  rsp_last_result,
   output logic                                  rsp_overflow
);

   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int VW    = qsort_pkg::VALUE_W;

   // control state
   logic [CNT_W-1:0] cnt_ff;
   logic             ovf_ff;
   logic [CNT_W-1:0] sp_ff;
   logic             rsp_valid_ff;
   // indexes and operands
   logic [IDX_W-1:0] lo_ff, hi_ff, j_ff, nxt_ff;
   logic [VW-1:0]    pivot_ff, aj_ff;
   logic [VW-1:0]    rsp_value_ff;
   logic             rsp_last_ff, rsp_ovf_ff;

   logic             full;
   logic [CNT_W-1:0] cnt_m1, sp_m1;
   logic [IDX_W:0]   lo_p1, nxt_p1;
   logic             out_xfer;

   logic             st_wr_en, st_rd_en;
   logic [IDX_W-1:0] st_wr_addr, st_rd_addr;
   logic [VW-1:0]    st_wr_data, st_rd_data;

   logic               sk_wr_en, sk_room;
   logic [2*IDX_W-1:0] sk_wr_data, sk_rd_data;
   logic [IDX_W-1:0]   sk_rd_lo, sk_rd_hi;

   assign full     = (cnt_ff == CNT_W'(MAX_ITEMS));
   assign cnt_m1   = cnt_ff - CNT_W'(1);
   assign sp_m1    = sp_ff - CNT_W'(1);
   assign lo_p1    = {1'b0, lo_ff} + (IDX_W+1)'(1);
   assign nxt_p1   = {1'b0, nxt_ff} + (IDX_W+1)'(1);
   assign out_xfer = rsp_valid_ff && !rsp_stall;
   assign sk_room  = (sp_ff < CNT_W'(MAX_ITEMS));
   assign sk_rd_lo = sk_rd_data[2*IDX_W-1:IDX_W];
   assign sk_rd_hi = sk_rd_data[IDX_W-1:0];

   // sample store port selection
   always_comb begin
      st_wr_en   = (cmd.load && !full) || cmd.wr_j_rd || cmd.wr_nxt_aj ||
                   cmd.wr_hi_rd || cmd.wr_nxt_pivot;
      st_wr_addr = cnt_ff[IDX_W-1:0];
      st_wr_data = req_sample_value;
      if (cmd.wr_j_rd) begin
         st_wr_addr = j_ff;
         st_wr_data = st_rd_data;
      end else if (cmd.wr_nxt_aj) begin
         st_wr_addr = nxt_ff;
         st_wr_data = aj_ff;
      end else if (cmd.wr_hi_rd) begin
         st_wr_addr = hi_ff;
         st_wr_data = st_rd_data;
      end else if (cmd.wr_nxt_pivot) begin
         st_wr_addr = nxt_ff;
         st_wr_data = pivot_ff;
      end
      st_rd_en   = cmd.read_pivot || cmd.read_j || cmd.read_nxt || cmd.emit_rd;
      if (cmd.read_pivot) begin
         st_rd_addr = hi_ff;
      end else if (cmd.read_nxt) begin
         st_rd_addr = nxt_ff;
      end else begin
         st_rd_addr = j_ff;
      end
   end

   qsort_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   // range stack holds (lo, hi) pairs
   always_comb begin
      sk_wr_en   = (cmd.push_init || cmd.push_left || cmd.push_right) && sk_room;
      sk_wr_data = {IDX_W'(0), cnt_m1[IDX_W-1:0]};
      if (cmd.push_left) begin
         sk_wr_data = {lo_ff, nxt_ff - IDX_W'(1)};
      end else if (cmd.push_right) begin
         sk_wr_data = {nxt_p1[IDX_W-1:0], hi_ff};
      end
   end

   qsort_ram #(
      .WIDTH (2 * IDX_W),
      .DEPTH (MAX_ITEMS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (sk_wr_en),
      .wr_addr (sp_ff[IDX_W-1:0]),
      .wr_data (sk_wr_data),
      .rd_en   (cmd.pop),
      .rd_addr (sp_m1[IDX_W-1:0]),
      .rd_data (sk_rd_data)
   );

   // load count, overflow flag, stack pointer, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load && !full) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (cmd.emit_done) begin
            cnt_ff <= '0;
         end
         if (cmd.load && full) begin
            ovf_ff <= 1'b1;
         end else if (cmd.emit_done) begin
            ovf_ff <= 1'b0;
         end
         if (sk_wr_en) begin
            sp_ff <= sp_ff + CNT_W'(1);
         end else if (cmd.pop) begin
            sp_ff <= sp_m1;
         end
         if (cmd.emit_ld) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_xfer) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // partition indexes, operands and output payload
   always_ff @(posedge clock) begin
      if (cmd.take_range) begin
         lo_ff  <= sk_rd_lo;
         hi_ff  <= sk_rd_hi;
         j_ff   <= sk_rd_lo;
         nxt_ff <= sk_rd_lo;
      end else begin
         if (cmd.emit_start) begin
            j_ff <= '0;
         end else if (cmd.inc_j) begin
            j_ff <= j_ff + IDX_W'(1);
         end
         if (cmd.inc_nxt) begin
            nxt_ff <= nxt_p1[IDX_W-1:0];
         end
      end
      if (cmd.take_pivot) begin
         pivot_ff <= st_rd_data;
      end
      if (cmd.take_aj) begin
         aj_ff <= st_rd_data;
      end
      if (cmd.emit_ld) begin
         rsp_value_ff <= st_rd_data;
         rsp_last_ff  <= (CNT_W'(j_ff) == cnt_m1);
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   // status to the controller
   always_comb begin
      status.few_items   = (cnt_ff < CNT_W'(2));
      status.stack_empty = (sp_ff == '0);
      status.range_ok    = (sk_rd_lo < sk_rd_hi);
      status.scan_end    = (j_ff == hi_ff);
      status.le_pivot    = ($signed(st_rd_data) <= $signed(pivot_ff));
      status.nxt_eq_j    = (nxt_ff == j_ff);
      status.nxt_eq_hi   = (nxt_ff == hi_ff);
      status.left_ok     = ({1'b0, nxt_ff} > lo_p1);
      status.right_ok    = (nxt_p1 < {1'b0, hi_ff});
      status.out_xfer    = out_xfer;
      status.out_last    = rsp_last_ff;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = $signed(rsp_value_ff);
   assign rsp_last_result  = rsp_last_ff;
   assign rsp_overflow     = rsp_ovf_ff;

endmodule
